@@ src/modular_arithmetic_unit_defines.svh @@
// Assertion macros shared by the checker.
`ifndef MODULAR_ARITHMETIC_UNIT_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define MAU_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MAU_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

@@ src/mau_pkg.sv @@
`default_nettype none
package mau_pkg;
  localparam int unsigned ModW = 31;
  localparam logic [ModW-1:0] ModReset = 31'd1000000007;

  typedef enum logic [2:0] {
    CmdAdd = 3'd0,
    CmdSub = 3'd1,
    CmdMul = 3'd2,
    CmdDiv = 3'd3,
    CmdPow = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic [62:0]        exponent;
  } in_t;

  typedef struct packed {
    logic [ModW-1:0] result;
    logic            no_inverse;
  } out_t;

  // Request to the shared serial unit.
  typedef struct packed {
    logic            start;
    logic            is_div;
    logic [31:0]     num;
    logic [31:0]     den;
    logic [ModW-1:0] x;
    logic [ModW-1:0] y;
  } unit_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [31:0] rem;
  } unit_rsp_t;
endpackage
`default_nettype wire

@@ src/mau_serial_unit.sv @@
`default_nettype none
// Shared bit-serial unit: modular multiply (x*y mod m, one bit of y per cycle)
// or unsigned restoring division (num / den, one quotient bit per cycle).
module mau_serial_unit import mau_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic [ModW-1:0] mod_i,
  input  wire unit_req_t req_i,
  output unit_rsp_t      rsp_o
);
  logic        busy_q, busy_d, div_q, div_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] acc_q, acc_d;
  logic [31:0] sh_q, sh_d, den_q, den_d;
  logic [ModW-1:0] x_q, x_d;
  logic [32:0] dbl, sum, trial;

  always_comb begin
    busy_d = busy_q; div_d = div_q; cnt_d = cnt_q;
    acc_d = acc_q; sh_d = sh_q; den_d = den_q; x_d = x_q;
    // Multiply: acc = 2*acc (+x), reduced by at most two subtracts.
    dbl = {acc_q[31:0], 1'b0};
    if (dbl >= {2'b0, mod_i}) dbl = dbl - {2'b0, mod_i};
    sum = dbl + (sh_q[30] ? {2'b0, x_q} : 33'd0);
    if (sum >= {2'b0, mod_i}) sum = sum - {2'b0, mod_i};
    // Divide: shift in next numerator bit.
    trial = {acc_q[31:0], sh_q[31]};
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1; div_d = req_i.is_div;
      acc_d = '0; x_d = req_i.x; den_d = req_i.den;
      sh_d = req_i.is_div ? req_i.num : {1'b0, req_i.y};
      cnt_d = req_i.is_div ? 6'd32 : 6'd31;
    end else if (busy_q) begin
      if (div_q) begin
        if (trial >= {1'b0, den_q}) begin
          acc_d = trial - {1'b0, den_q};
          sh_d = {sh_q[30:0], 1'b1};
        end else begin
          acc_d = trial;
          sh_d = {sh_q[30:0], 1'b0};
        end
      end else begin
        acc_d = sum;
        sh_d = {sh_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  // Completion pulse in the cycle after the last step.
  logic fin_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; div_q <= 1'b0; fin_q <= 1'b0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d; div_q <= div_d;
      fin_q <= busy_q && cnt_q == 6'd1;
    end
  end
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; sh_q <= sh_d; den_q <= den_d; x_q <= x_d;
  end
  assign rsp_o = '{done: fin_q, quo: sh_q, rem: acc_q[31:0]};
endmodule
`default_nettype wire

@@ src/modular_arithmetic_unit.sv @@
`default_nettype none
// Modular arithmetic unit.
// Input channel in_valid_i/in_ready_o carries one command beat (add, subtract,
// multiply, divide, power) with two signed operands and an exponent. The
// output channel out_valid_o/out_ready_i returns one beat per command: the
// result in [0, modulus-1] and a no-inverse flag for divide.
// The modulus is written through cfg_valid_i/cfg_ready_o while idle; reset
// loads 1000000007. An input beat waits while a modulus write is offered.
// One item at a time: in_ready_o is low from acceptance until the result
// beat has been taken. Multiplies and divisions run in one shared bit-serial
// unit; add, subtract and the Euclid coefficient update are done locally.
// Operand reduction takes two divisions. Add and subtract need nothing more,
// multiply one multiply, divide one division and one multiply per Euclid
// step (up to ~45 steps) plus one multiply, power one squaring per exponent
// bit plus one multiply per set bit, up to 63 bits.
// A stalled receiver holds the result beat; no new item is taken meanwhile.
module modular_arithmetic_unit import mau_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_valid_i,
  output logic      cfg_ready_o,
  input  wire logic [ModW-1:0] cfg_data_i,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);
  typedef enum logic [3:0] {
    SIdle, SRedA, SRedB, SOp, SEuc, SEucT1, SEucT2, SPowM, SPowS, SDivM, SOut
  } state_e;

  state_e state_q;
  logic [ModW-1:0] mod_q;
  in_t  it_q;
  logic [ModW-1:0] a_q, b_q, acc_q, base_q;
  logic [62:0] e_q;
  logic [31:0] r0_q, r1_q, q_q;
  logic [ModW-1:0] t0_q, t1_q, tmp_q;
  logic wait_q;
  unit_req_t req;
  unit_rsp_t rsp;

  mau_serial_unit u_unit (
    .clk_i(clk_i), .rst_ni(rst_ni), .mod_i(mod_q), .req_i(req), .rsp_o(rsp)
  );

  assign cfg_ready_o = (state_q == SIdle);
  assign in_ready_o  = (state_q == SIdle) && !cfg_valid_i;

  // Signed operand magnitude and residue fix-up.
  logic [31:0] mag;
  logic neg;
  logic [31:0] rfix;
  always_comb begin
    logic signed [31:0] v;
    v = (state_q == SRedA) ? it_q.operand_a : it_q.operand_b;
    neg = v[31];
    mag = neg ? (32'd0 - v) : v;
    rfix = (neg && rsp.rem != 32'd0) ? ({1'b0, mod_q} - rsp.rem) : rsp.rem;
  end

  // Request to the shared unit; start is held while waiting for done.
  always_comb begin
    req = '0;
    req.start = wait_q && !rsp.done && (state_q != SEucT2);
    unique case (state_q)
      SRedA, SRedB: begin
        req.is_div = 1'b1; req.num = mag; req.den = {1'b0, mod_q};
      end
      SEuc: begin
        req.is_div = 1'b1; req.num = r0_q; req.den = r1_q;
      end
      SEucT1: begin req.x = q_q[ModW-1:0]; req.y = t1_q; end
      SOp, SDivM: begin req.x = a_q; req.y = (state_q == SDivM) ? t0_q : b_q; end
      SPowM: begin req.x = acc_q; req.y = base_q; end
      SPowS: begin req.x = base_q; req.y = base_q; end
      default: ;
    endcase
  end

  // Add and subtract of residues; operand b is the residue just produced.
  logic [31:0] s_add, s_sub;
  always_comb begin
    s_add = {1'b0, a_q} + {1'b0, rfix[ModW-1:0]};
    if (s_add >= {1'b0, mod_q}) s_add = s_add - {1'b0, mod_q};
    s_sub = {1'b0, a_q} - {1'b0, rfix[ModW-1:0]};
    if (a_q < rfix[ModW-1:0]) s_sub = s_sub + {1'b0, mod_q};
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; mod_q <= ModReset; wait_q <= 1'b0; out_valid_o <= 1'b0;
    end else begin
      unique case (state_q)
        SIdle: begin
          if (cfg_valid_i) mod_q <= cfg_data_i;
          if (in_valid_i && in_ready_o) begin
            it_q <= in_data_i;
            if (mod_q <= 31'd1 || in_data_i.command > 3'(CmdPow)) begin
              out_data_o <= '0; out_valid_o <= 1'b1; state_q <= SOut;
            end else begin
              state_q <= SRedA; wait_q <= 1'b1;
            end
          end
        end
        SRedA: if (rsp.done) begin a_q <= rfix[ModW-1:0]; state_q <= SRedB; end
        SRedB: if (rsp.done) begin
          b_q <= rfix[ModW-1:0];
          unique case (it_q.command)
            3'(CmdAdd): begin
              out_data_o <= '{result: s_add[ModW-1:0], no_inverse: 1'b0};
              wait_q <= 1'b0; out_valid_o <= 1'b1; state_q <= SOut;
            end
            3'(CmdSub): begin
              out_data_o <= '{result: s_sub[ModW-1:0], no_inverse: 1'b0};
              wait_q <= 1'b0; out_valid_o <= 1'b1; state_q <= SOut;
            end
            3'(CmdMul): state_q <= SOp;
            3'(CmdDiv): begin
              r0_q <= {1'b0, mod_q}; r1_q <= rfix; t0_q <= '0; t1_q <= 31'd1;
              if (rfix == 32'd0) begin
                out_data_o <= '{result: '0, no_inverse: 1'b1};
                wait_q <= 1'b0; out_valid_o <= 1'b1; state_q <= SOut;
              end else state_q <= SEuc;
            end
            default: begin
              acc_q <= 31'd1; base_q <= a_q; e_q <= it_q.exponent;
              if (it_q.exponent == 63'd0) begin
                out_data_o <= '{result: 31'd1, no_inverse: 1'b0};
                wait_q <= 1'b0; out_valid_o <= 1'b1; state_q <= SOut;
              end else state_q <= it_q.exponent[0] ? SPowM : SPowS;
            end
          endcase
        end
        SOp: if (rsp.done) begin
          out_data_o <= '{result: rsp.rem[ModW-1:0], no_inverse: 1'b0};
          wait_q <= 1'b0; out_valid_o <= 1'b1; state_q <= SOut;
        end
        // Euclid step: q = r0/r1, then t update mod m via one multiply.
        SEuc: if (rsp.done) begin
          q_q <= rsp.quo; r0_q <= r1_q; r1_q <= rsp.rem; state_q <= SEucT1;
        end
        SEucT1: if (rsp.done) begin tmp_q <= rsp.rem[ModW-1:0]; state_q <= SEucT2; end
        SEucT2: begin
          t0_q <= t1_q;
          t1_q <= (t0_q >= tmp_q) ? (t0_q - tmp_q) : (t0_q + mod_q - tmp_q);
          if (r1_q == 32'd0) begin
            if (r0_q != 32'd1) begin
              out_data_o <= '{result: '0, no_inverse: 1'b1};
              wait_q <= 1'b0; out_valid_o <= 1'b1; state_q <= SOut;
            end else state_q <= SDivM;
          end else state_q <= SEuc;
        end
        SDivM: if (rsp.done) begin
          out_data_o <= '{result: rsp.rem[ModW-1:0], no_inverse: 1'b0};
          wait_q <= 1'b0; out_valid_o <= 1'b1; state_q <= SOut;
        end
        SPowM: if (rsp.done) begin acc_q <= rsp.rem[ModW-1:0]; state_q <= SPowS; end
        SPowS: if (rsp.done) begin
          base_q <= rsp.rem[ModW-1:0];
          e_q <= e_q >> 1;
          if (e_q[62:1] == 62'd0) begin
            out_data_o <= '{result: acc_q, no_inverse: 1'b0};
            wait_q <= 1'b0; out_valid_o <= 1'b1; state_q <= SOut;
          end else state_q <= e_q[1] ? SPowM : SPowS;
        end
        SOut: if (out_ready_i) begin out_valid_o <= 1'b0; state_q <= SIdle; end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ src/mau_checker.sv @@
`default_nettype none
`include "modular_arithmetic_unit_defines.svh"
// Port-level checks for the modular arithmetic unit.
module mau_checker import mau_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_data_o
);
  // No input is taken while a result beat is pending.
  `MAU_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_valid_o, !in_ready_o)
  // A stalled result beat holds its payload.
  `MAU_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o))
  // An accepted item drops ready.
  `MAU_ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // The no-inverse flag comes only with result zero.
  `MAU_ASSERT_IMP(a_noinv, clk_i, rst_ni, out_valid_o && out_data_o.no_inverse,
    out_data_o.result == '0)
endmodule
bind modular_arithmetic_unit mau_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
);
`default_nettype wire
